// ===== src/instruction_signature_classifier_core_assert.svh =====
// Assertion macros used by the classifier back stage (isc_back).
// No dependencies; include by bare file name.
`ifndef INSTRUCTION_SIGNATURE_CLASSIFIER_CORE_ASSERT_SVH
`define INSTRUCTION_SIGNATURE_CLASSIFIER_CORE_ASSERT_SVH

// Same-cycle implication under reset.
`define ISC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under reset.
`define ISC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/isc_pkg.sv =====
// Package for the instruction signature classifier: pattern table,
// queue item type, output beat layout and register indexes. No dependencies.
package isc_pkg;

    localparam int BUILTIN_ENTRIES = 23;
    localparam int TABLE_ENTRIES_DEF = 23;
    localparam int MAX_WORDS_DEF = 1024;
    localparam int QUEUE_DEPTH = 2;

    localparam int WORD_W = 32;
    localparam int POS_OUT_W = 10;
    localparam int IDX_W = 5;
    localparam int NBITS_W = 6;
    localparam int COUNT_W = 11;
    localparam int TOTAL_W = 11;
    localparam int RATIO_W = 18;
    localparam int OUT_FIELDS_W = POS_OUT_W + 1 + IDX_W + WORD_W + WORD_W + NBITS_W
                                  + COUNT_W + 1;
    localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_INDEX_W-1:0] CFG_WORD_TOTAL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_MODE = 2'd1;

    localparam logic [TOTAL_W-1:0] WORD_TOTAL_RST = 11'd1024;
    localparam logic [WORD_W-1:0] RET_WORD = 32'he1a0f00e;
    localparam logic [WORD_W-1:0] OFFSET_BITS = 32'h00000fff;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;
    localparam logic [6:0] RATIO_NUM = 7'd100;
    localparam logic [6:0] RATIO_DEN = 7'd76;

    localparam logic [WORD_W-1:0] PAT_VALUE [BUILTIN_ENTRIES] = '{
        32'h008f0000, 32'h00800000, 32'h02000000, 32'h0a000000, 32'h01c00000,
        32'h01700000, 32'h01500000, 32'h08100000, 32'h041f0000, 32'h04100000,
        32'h01af0000, 32'h01a00000, 32'h00000090, 32'h01ef0000, 32'h01e00000,
        32'h00600000, 32'h00e00000, 32'h08000000, 32'h04000000, 32'h04400000,
        32'h004f0000, 32'h00400000, 32'h01100000
    };

    localparam logic [WORD_W-1:0] PAT_MASK [BUILTIN_ENTRIES] = '{
        32'h0def0000, 32'h0de00000, 32'h0fe00000, 32'h0e000000, 32'h0de00000,
        32'h0df00000, 32'h0df00000, 32'h0e500000, 32'h0c5f0000, 32'h0c500000,
        32'h0def0000, 32'h0de00000, 32'h0fe000f0, 32'h0def0000, 32'h0de00000,
        32'h0de00000, 32'h0de00000, 32'h0e500000, 32'h0c500000, 32'h0c500000,
        32'h0def0000, 32'h0de00000, 32'h0df00000
    };

    localparam logic [WORD_W-1:0] PAT_IGNORE [BUILTIN_ENTRIES] = '{
        32'h0ff00fff, 32'h020f0fff, 32'h00000fff, 32'hf0ffffff, 32'h02000fff,
        32'h02000000, 32'h02000fff, 32'h0000ffff, 32'h0ff00fff, 32'h02000fff,
        32'h0ff00fff, 32'h02000fff, 32'h00000000, 32'h0ff00fff, 32'h02000fff,
        32'h02000000, 32'h02000000, 32'h0000ffff, 32'h02000fff, 32'h02000fff,
        32'h0ff00fff, 32'h02000fff, 32'h02000000
    };

    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic               hit;
        logic [IDX_W-1:0]   idx;
        logic [WORD_W-1:0]  ign;
        logic [NBITS_W-1:0] nbits;
        logic               is_ret;
    } item_t;

    typedef struct packed {
        logic                   valid;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_wr_t;

    function automatic logic [NBITS_W-1:0] popcount32(input logic [WORD_W-1:0] v);
        logic [NBITS_W-1:0] n;
        n = '0;
        for (int k = 0; k < WORD_W; k++) begin
            n = n + NBITS_W'(v[k]);
        end
        return n;
    endfunction

endpackage

// ===== src/instruction_signature_classifier_core.sv =====
// Each input beat is written into the queue, then registered in the output register.
// Throughput: one beat per cycle unless output stalls; table compare is combinational.
// Queue of 2 items decouples classification from counter update and output stall.
// Reset (rst_n low, async): counters, stop flag, queue and output valid clear;
// word_total returns to 1024 and offset_mode to 0. No clearing pass.
module instruction_signature_classifier_core #(
    parameter int TABLE_ENTRIES = isc_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_WORDS     = isc_pkg::MAX_WORDS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [31:0] instr_word
    input  logic [isc_pkg::WORD_W-1:0]          s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [9:0] position, [10] matched, [15:11] entry_index, [47:16] masked_word,
    // [79:48] keep_mask, [85:80] mask_bits, [96:86] match_count, [97] stop
    output logic [isc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [isc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [isc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    isc_pkg::item_t   front_item;
    isc_pkg::item_t   queue_item;
    logic             queue_valid;
    logic             queue_ready;
    isc_pkg::cfg_wr_t cfg_wr;

    assign cfg_ready    = 1'b1;
    assign cfg_wr.valid = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    isc_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_front (
        .word (s_axis_tdata),
        .item (front_item)
    );

    isc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (s_axis_tvalid),
        .push_ready (s_axis_tready),
        .push_item  (front_item),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_item   (queue_item)
    );

    isc_back #(
        .MAX_WORDS (MAX_WORDS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr     (cfg_wr),
        .item_valid (queue_valid),
        .item_ready (queue_ready),
        .item       (queue_item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata)
    );

endmodule

// ===== src/isc_front.sv =====
// Front stage: compares one word against the priority pattern table and
// builds a queue item. Depends on isc_pkg.
module isc_front #(
    parameter int TABLE_ENTRIES = isc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic [isc_pkg::WORD_W-1:0] word,
    output isc_pkg::item_t             item
);

    localparam int LIMIT = (TABLE_ENTRIES < isc_pkg::BUILTIN_ENTRIES) ?
                           TABLE_ENTRIES : isc_pkg::BUILTIN_ENTRIES;

    always_comb
    begin
        item.word   = word;
        item.hit    = 1'b0;
        item.idx    = '0;
        item.ign    = '0;
        item.nbits  = '0;
        item.is_ret = (word == isc_pkg::RET_WORD);
        for (int j = LIMIT - 1; j >= 0; j--) begin
            if ((word & isc_pkg::PAT_MASK[j]) == isc_pkg::PAT_VALUE[j]) begin
                item.hit   = 1'b1;
                item.idx   = isc_pkg::IDX_W'(j);
                item.ign   = isc_pkg::PAT_IGNORE[j];
                item.nbits = isc_pkg::popcount32(isc_pkg::PAT_MASK[j]);
            end
        end
    end

endmodule

// ===== src/isc_queue.sv =====
// Short queue of classified items between front and back stages.
// Depends on isc_pkg.
module isc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  isc_pkg::item_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output isc_pkg::item_t pop_item
);

    localparam int PTR_W = (isc_pkg::QUEUE_DEPTH > 1) ? $clog2(isc_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(isc_pkg::QUEUE_DEPTH + 1);

    isc_pkg::item_t   slot_reg [isc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(isc_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(isc_pkg::QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(isc_pkg::QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== src/isc_back.sv =====
// Back stage: configuration registers, word and match counters, stop test
// and the output register. Depends on isc_pkg and the assertion header.
`include "instruction_signature_classifier_core_assert.svh"

module isc_back #(
    parameter int MAX_WORDS = isc_pkg::MAX_WORDS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  isc_pkg::cfg_wr_t                   cfg_wr,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  isc_pkg::item_t                     item,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [isc_pkg::OUT_TDATA_W-1:0]    out_data
);

    localparam int POS_W = $clog2(MAX_WORDS);

    logic [isc_pkg::TOTAL_W-1:0]   word_total_reg;
    logic                          offset_mode_reg;
    logic [POS_W-1:0]              word_pos_reg, word_pos_next;
    logic [isc_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic                          stopped_reg, stopped_next;
    logic                          out_valid_reg, out_valid_next;
    logic [isc_pkg::OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    logic                          load;
    logic                          hit_eff;
    logic [isc_pkg::WORD_W-1:0]    keep;
    logic [isc_pkg::RATIO_W-1:0]   lhs, rhs;
    logic [isc_pkg::POS_OUT_W-1:0] pos_out;

    assign item_ready = !out_valid_reg || out_ready;
    assign load       = item_valid && item_ready;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    generate
        if (POS_W >= isc_pkg::POS_OUT_W) begin : g_pos_trunc
            assign pos_out = word_pos_reg[isc_pkg::POS_OUT_W-1:0];
        end else begin : g_pos_ext
            assign pos_out = isc_pkg::POS_OUT_W'(word_pos_reg);
        end
    endgenerate

    always_comb
    begin
        hit_eff = item.hit && !stopped_reg;
        keep    = ~item.ign | (offset_mode_reg ? isc_pkg::OFFSET_BITS : '0);

        count_next = count_reg;
        if (hit_eff && (count_reg < isc_pkg::COUNT_MAX)) begin
            count_next = count_reg + 1'b1;
        end

        lhs = isc_pkg::RATIO_W'(word_total_reg) * isc_pkg::RATIO_W'(isc_pkg::RATIO_NUM);
        rhs = isc_pkg::RATIO_W'(count_next) * isc_pkg::RATIO_W'(isc_pkg::RATIO_DEN);

        stopped_next = stopped_reg || (hit_eff && item.is_ret && (lhs >= rhs));

        word_pos_next = (word_pos_reg == POS_W'(MAX_WORDS - 1)) ? '0
                        : word_pos_reg + 1'b1;

        out_data_next = '0;
        out_data_next[isc_pkg::OUT_FIELDS_W-1:0] = {
            stopped_next,
            count_next,
            hit_eff ? item.nbits : {isc_pkg::NBITS_W{1'b0}},
            hit_eff ? keep : {isc_pkg::WORD_W{1'b0}},
            hit_eff ? (item.word & keep) : {isc_pkg::WORD_W{1'b0}},
            hit_eff ? item.idx : {isc_pkg::IDX_W{1'b0}},
            hit_eff,
            pos_out
        };

        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            word_total_reg  <= isc_pkg::WORD_TOTAL_RST;
            offset_mode_reg <= 1'b0;
        end else if (cfg_wr.valid) begin
            case (cfg_wr.index)
                isc_pkg::CFG_WORD_TOTAL:  word_total_reg  <= cfg_wr.data;
                isc_pkg::CFG_OFFSET_MODE: offset_mode_reg <= cfg_wr.data[0];
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            word_pos_reg  <= '0;
            count_reg     <= '0;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (load) begin
                word_pos_reg <= word_pos_next;
                count_reg    <= count_next;
                stopped_reg  <= stopped_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            out_data_reg <= out_data_next;
        end
    end

    `ISC_ASSERT_NEXT(a_stop_sticky, clk, rst_n, stopped_reg, stopped_reg,
                     "stop flag cleared without reset")
    `ISC_ASSERT_NEXT(a_stopped_no_match, clk, rst_n, load && stopped_reg,
                     !out_data_reg[isc_pkg::POS_OUT_W],
                     "match reported after stop")
    `ISC_ASSERT_NEXT(a_count_hold, clk, rst_n, !load, $stable(count_reg),
                     "match count moved without a beat")
    `ISC_ASSERT_SAME(a_hit_has_mask, clk, rst_n, load && hit_eff, item.nbits != '0,
                     "matched entry with empty mask")

endmodule

// ===== tb/isc_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the instruction signature classifier: follows the input, output and
// register channels, predicts every output beat and compares it field by field.
// Depends on isc_pkg for widths, the pattern table and the register indexes.
module isc_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [isc_pkg::WORD_W-1:0]      s_axis_tdata,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [isc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [isc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [isc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              fail_count,
    output int                              outstanding,
    output logic [isc_pkg::COUNT_W-1:0]     hit_total
);
    import isc_pkg::*;

    typedef struct packed {
        logic               stop;
        logic [COUNT_W-1:0] count;
        logic [NBITS_W-1:0] nbits;
        logic [WORD_W-1:0]  keep;
        logic [WORD_W-1:0]  masked;
        logic [IDX_W-1:0]   idx;
        logic               hit;
        logic [POS_OUT_W-1:0] pos;
    } class_beat_t;

    class_beat_t        pending_classes [$];
    logic [POS_OUT_W-1:0] word_pos;
    logic [COUNT_W-1:0] hits;
    logic               halted;
    logic [TOTAL_W-1:0] total;
    logic               offset_on;
    int                 bad_beats = 0;

    function automatic class_beat_t classify_word(input logic [WORD_W-1:0] w);
        class_beat_t        b;
        logic [COUNT_W-1:0] n;
        logic               ends;
        b = '0;
        b.pos = word_pos;
        n = hits;
        ends = 1'b0;
        if (!halted) begin
            for (int j = 0; j < BUILTIN_ENTRIES; j++) begin
                if (!b.hit && (w & PAT_MASK[j]) == PAT_VALUE[j]) begin
                    b.hit = 1'b1;
                    b.idx = IDX_W'(j);
                end
            end
            if (b.hit) begin
                b.keep = ~PAT_IGNORE[b.idx] | (offset_on ? OFFSET_BITS : '0);
                b.masked = w & b.keep;
                b.nbits = NBITS_W'($countones(PAT_MASK[b.idx]));
                if (n != COUNT_MAX)
                    n = n + 1'b1;
                if (w == RET_WORD && 32'(total) * 32'd100 >= 32'(n) * 32'd76)
                    ends = 1'b1;
            end
        end
        b.count = n;
        b.stop = halted | ends;
        return b;
    endfunction

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
            bad_beats++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        class_beat_t want;
        class_beat_t got;
        if (!rst_n) begin
            pending_classes.delete();
            word_pos = '0;
            hits = '0;
            halted = 1'b0;
            total = WORD_TOTAL_RST;
            offset_on = 1'b0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_WORD_TOTAL)
                    total = cfg_data;
                else if (cfg_index == CFG_OFFSET_MODE)
                    offset_on = cfg_data[0];
            end
            if (s_axis_tvalid && s_axis_tready) begin
                want = classify_word(s_axis_tdata);
                pending_classes.push_back(want);
                hits = want.count;
                halted = want.stop;
                word_pos = word_pos + 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = class_beat_t'(m_axis_tdata[OUT_FIELDS_W-1:0]);
                if (pending_classes.size() == 0) begin
                    $display("%0t ns: output beat with nothing expected, actual %h",
                             $time, got);
                    bad_beats++;
                end
                else begin
                    want = pending_classes.pop_front();
                    check_field("position", WORD_W'(want.pos), WORD_W'(got.pos));
                    check_field("matched", WORD_W'(want.hit), WORD_W'(got.hit));
                    check_field("entry_index", WORD_W'(want.idx), WORD_W'(got.idx));
                    check_field("masked_word", want.masked, got.masked);
                    check_field("keep_mask", want.keep, got.keep);
                    check_field("mask_bits", WORD_W'(want.nbits), WORD_W'(got.nbits));
                    check_field("match_count", WORD_W'(want.count), WORD_W'(got.count));
                    check_field("stop", WORD_W'(want.stop), WORD_W'(got.stop));
                end
            end
        end
        fail_count <= bad_beats;
        outstanding <= pending_classes.size();
        hit_total <= hits;
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the classifier testbench: clock, reset, stimulus and register writes for
// instruction_signature_classifier_core, with isc_checker judging every output beat.
module tb_top;
    import isc_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [WORD_W-1:0]      s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int                 fail_count;
    int                 outstanding;
    logic [COUNT_W-1:0] hit_total;
    int                 src_idle_pct = 0;
    int                 sink_stall_pct = 0;
    int                 words_sent = 0;

    always #5 clk = ~clk;

    instruction_signature_classifier_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    isc_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .hit_total     (hit_total)
    );

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

    function automatic logic [WORD_W-1:0] entry_word();
        int j;
        j = $urandom_range(BUILTIN_ENTRIES - 1);
        return ($urandom & ~PAT_MASK[j]) | PAT_VALUE[j];
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return entry_word();
        else if (r < 90)
            return $urandom;
        else if (r < 95)
            return RET_WORD;
        else
            return $urandom_range(1) ? '1 : '0;
    endfunction

    task automatic send_word(input logic [WORD_W-1:0] w);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= w;
        do @(posedge clk); while (!s_axis_tready);
        words_sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data, input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        if (last)
            cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic run_mix(input int idle_pct, input int stall_pct, input int n);
        logic [TOTAL_W-1:0] t;
        drain_results();
        src_idle_pct = idle_pct;
        sink_stall_pct = stall_pct;
        case ($urandom_range(2))
            0:       t = '0;
            1:       t = TOTAL_W'(1);
            default: t = TOTAL_W'($urandom_range(15));
        endcase
        write_reg(CFG_WORD_TOTAL, t, 1'b0);
        write_reg(CFG_OFFSET_MODE, CFG_DATA_W'($urandom_range(2047)), 1'b1);
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 2)
                drain_results();
            send_word(pick_word());
        end
    endtask

    initial
    begin
        logic [COUNT_W-1:0] c_next;
        logic [TOTAL_W-1:0] t_edge;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_WORD_TOTAL;
        cfg_data = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        send_word('0);
        send_word('1);
        for (int j = 0; j < BUILTIN_ENTRIES; j++)
            send_word(PAT_VALUE[j]);

        // hold the ratio test below threshold: total 1 against a count above twenty
        drain_results();
        write_reg(CFG_WORD_TOTAL, TOTAL_W'(1), 1'b0);
        write_reg(CFG_OFFSET_MODE, CFG_DATA_W'(1), 1'b0);
        write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom_range(2047)), 1'b0);
        write_reg(CFG_SPARE_B, CFG_DATA_W'($urandom_range(2047)), 1'b1);
        send_word(RET_WORD);
        send_word('1);

        run_mix(0, 0, 190);
        run_mix(79, 0, 190);
        run_mix(0, 79, 190);
        run_mix(16, 16, 190);

        // approach the stop threshold from just below, then land on it
        drain_results();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        c_next = (hit_total == COUNT_MAX) ? hit_total : hit_total + 1'b1;
        t_edge = TOTAL_W'((76 * int'(c_next) + 99) / 100 - 1);
        write_reg(CFG_WORD_TOTAL, t_edge, 1'b1);
        send_word(RET_WORD);
        drain_results();
        c_next = (hit_total == COUNT_MAX) ? hit_total : hit_total + 1'b1;
        t_edge = TOTAL_W'((76 * int'(c_next) + 99) / 100);
        write_reg(CFG_WORD_TOTAL, t_edge, 1'b1);
        send_word(RET_WORD);

        drain_results();
        src_idle_pct = 16;
        sink_stall_pct = 16;
        write_reg(CFG_WORD_TOTAL, '1, 1'b0);
        write_reg(CFG_OFFSET_MODE, CFG_DATA_W'(0), 1'b1);
        for (int i = 0; i < 60; i++)
            send_word(pick_word());

        drain_results();
        repeat (4) @(posedge clk);
        $display("covered %0d words: four idle/stall mixes, both offset modes, count at %0d,",
                 words_sent, hit_total);
        $display("stop threshold missed by one and then met, words after stop");
        if (fail_count == 0 && outstanding == 0)
            $display("instruction_signature_classifier_core: match");
        else
            $display("instruction_signature_classifier_core: mismatch");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("instruction_signature_classifier_core: mismatch");
        $finish;
    end

endmodule
